// ----- rtl/aifs_pkg.sv -----
`timescale 1ns / 1ps
// Package: shared types, codes and constants of the affine IFS point generator.
package aifs_pkg;

    localparam int MAX_MAPS_DEF    = 8;
    localparam int POINT_WIDTH_DEF = 32;
    localparam int COEFS_PER_MAP   = 6;

    localparam logic [6:0]  THRESH_RESET      = 7'd100;
    localparam logic [3:0]  MAPS_IN_USE_RESET = 4'd1;
    localparam logic [15:0] WARMUP_RESET      = 16'd100;
    localparam logic [15:0] STEP_COUNT_MAX    = 16'hFFFF;

    typedef enum logic [1:0] {
        CMD_LOAD_COEF   = 2'd0,
        CMD_LOAD_THRESH = 2'd1,
        CMD_STEP        = 2'd2,
        CMD_RESTART     = 2'd3
    } t_cmd;

    // coefficient slot order inside one map
    typedef enum logic [2:0] {
        SLOT_A = 3'd0,
        SLOT_B = 3'd1,
        SLOT_E = 3'd2,
        SLOT_C = 3'd3,
        SLOT_D = 3'd4,
        SLOT_F = 3'd5
    } t_slot;

    typedef enum logic {
        REG_MAPS_IN_USE  = 1'b0,
        REG_WARMUP_STEPS = 1'b1
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_MUL,
        S_ACC,
        S_TERM,
        S_ADD,
        S_BOX,
        S_DONE
    } t_state;

    typedef struct packed {
        t_cmd               cmd;
        logic [2:0]         map_index;
        logic [2:0]         coef_index;
        logic signed [31:0] load_value;
        logic [6:0]         random_percent;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic [2:0]         map_chosen;
        logic               past_warmup;
        logic signed [31:0] box_x_min;
        logic signed [31:0] box_x_max;
        logic signed [31:0] box_y_min;
        logic signed [31:0] box_y_max;
    } t_out_item;

    // strobes from the sequencer to the datapath and the top level
    typedef struct packed {
        logic ram_re;
        logic mul;
        logic acc;
        logic term;
        logic coef_add;
        logic sum_clr;
        logic store_x;
        logic store_y;
        logic box;
        logic done;
    } t_ctrl;

endpackage

// ----- rtl/aifs_ram.sv -----
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
module aifs_ram #(
    parameter int WIDTH = aifs_pkg::POINT_WIDTH_DEF,
    parameter int DEPTH = aifs_pkg::MAX_MAPS_DEF * aifs_pkg::COEFS_PER_MAP,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/aifs_mac.sv -----
`timescale 1ns / 1ps
// Shared multiply-accumulate unit: chunked product, floor shift, sum and saturation.
module aifs_mac #(
    parameter int POINT_WIDTH = aifs_pkg::POINT_WIDTH_DEF,
    localparam int NPASS      = (POINT_WIDTH + 31) / 32,
    localparam int PASS_W     = (NPASS > 1) ? $clog2(NPASS) : 1
) (
    input  logic                          i_clk,
    input  aifs_pkg::t_ctrl               i_ctrl,
    input  logic [PASS_W-1:0]             i_pass,
    input  logic signed [POINT_WIDTH-1:0] i_coef,
    input  logic signed [POINT_WIDTH-1:0] i_point,
    output logic signed [POINT_WIDTH-1:0] o_sat
);

    localparam int CHUNK  = (POINT_WIDTH + NPASS - 1) / NPASS;
    localparam int FRAC   = POINT_WIDTH - 8;
    localparam int EXT_W  = NPASS * CHUNK;
    localparam int PROD_W = POINT_WIDTH + CHUNK + 1;
    localparam int ACC_W  = POINT_WIDTH + EXT_W + 2;
    localparam int SUM_W  = POINT_WIDTH + 10;

    localparam logic signed [SUM_W-1:0] SAT_HI =
        {{(SUM_W - POINT_WIDTH + 1){1'b0}}, {(POINT_WIDTH - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_LO =
        {{(SUM_W - POINT_WIDTH + 1){1'b1}}, {(POINT_WIDTH - 1){1'b0}}};
    localparam logic signed [POINT_WIDTH-1:0] PT_MAX = {1'b0, {(POINT_WIDTH - 1){1'b1}}};
    localparam logic signed [POINT_WIDTH-1:0] PT_MIN = {1'b1, {(POINT_WIDTH - 1){1'b0}}};

    logic signed [EXT_W-1:0]  w_pt_ext;
    logic [EXT_W-1:0]         w_pt_shr;
    logic signed [CHUNK:0]    w_op;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  w_term_full;
    logic signed [SUM_W-1:0]  w_term;
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [SUM_W-1:0]  w_sum_add;

    // top chunk first, signed; lower chunks unsigned
    assign w_pt_ext = EXT_W'(i_point);
    assign w_pt_shr = w_pt_ext >> (CHUNK * (NPASS - 1 - int'(i_pass)));
    assign w_op     = {((i_pass == '0) ? i_point[POINT_WIDTH-1] : 1'b0),
                       w_pt_shr[CHUNK-1:0]};

    assign w_term_full = r_acc >>> FRAC;
    assign w_term      = SUM_W'(w_term_full);
    assign w_sum_add   = r_sum + SUM_W'(i_coef);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul) begin
            r_prod <= i_coef * w_op;
        end
        if (i_ctrl.acc) begin
            if (i_pass == '0) begin
                r_acc <= ACC_W'(r_prod);
            end else begin
                r_acc <= (r_acc <<< CHUNK) + ACC_W'(r_prod);
            end
        end
        if (i_ctrl.sum_clr) begin
            r_sum <= '0;
        end else if (i_ctrl.term) begin
            r_sum <= r_sum + w_term;
        end else if (i_ctrl.coef_add) begin
            r_sum <= w_sum_add;
        end
    end

    // saturate the sum that includes the offset coefficient
    always_comb begin
        if (w_sum_add > SAT_HI) begin
            o_sat = PT_MAX;
        end else if (w_sum_add < SAT_LO) begin
            o_sat = PT_MIN;
        end else begin
            o_sat = POINT_WIDTH'(w_sum_add);
        end
    end

endmodule

// ----- rtl/aifs_seq.sv -----
`timescale 1ns / 1ps
// Sequencer that walks the six coefficients of one map through the shared unit.
module aifs_seq #(
    parameter int POINT_WIDTH = aifs_pkg::POINT_WIDTH_DEF,
    localparam int NPASS      = (POINT_WIDTH + 31) / 32,
    localparam int PASS_W     = (NPASS > 1) ? $clog2(NPASS) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_out_free,
    output aifs_pkg::t_state   o_state,
    output aifs_pkg::t_ctrl    o_ctrl,
    output aifs_pkg::t_slot    o_slot,
    output logic [PASS_W-1:0]  o_pass
);

    localparam logic [PASS_W-1:0] LAST_PASS = PASS_W'(NPASS - 1);

    aifs_pkg::t_state  r_state, n_state;
    aifs_pkg::t_slot   r_slot, n_slot;
    logic [PASS_W-1:0] r_pass, n_pass;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= aifs_pkg::S_IDLE;
            r_slot  <= aifs_pkg::SLOT_A;
            r_pass  <= '0;
        end else begin
            r_state <= n_state;
            r_slot  <= n_slot;
            r_pass  <= n_pass;
        end
    end

    always_comb begin
        n_state = r_state;
        n_slot  = r_slot;
        n_pass  = r_pass;
        case (r_state)
            aifs_pkg::S_IDLE: begin
                if (i_start) begin
                    n_state = aifs_pkg::S_READ;
                    n_slot  = aifs_pkg::SLOT_A;
                    n_pass  = '0;
                end
            end
            aifs_pkg::S_READ: begin
                if (r_slot == aifs_pkg::SLOT_E || r_slot == aifs_pkg::SLOT_F) begin
                    n_state = aifs_pkg::S_ADD;
                end else begin
                    n_state = aifs_pkg::S_MUL;
                end
            end
            aifs_pkg::S_MUL: begin
                n_state = aifs_pkg::S_ACC;
            end
            aifs_pkg::S_ACC: begin
                if (r_pass == LAST_PASS) begin
                    n_state = aifs_pkg::S_TERM;
                    n_pass  = '0;
                end else begin
                    n_state = aifs_pkg::S_MUL;
                    n_pass  = r_pass + PASS_W'(1);
                end
            end
            aifs_pkg::S_TERM: begin
                n_state = aifs_pkg::S_READ;
                n_slot  = aifs_pkg::t_slot'(r_slot + 3'd1);
            end
            aifs_pkg::S_ADD: begin
                if (r_slot == aifs_pkg::SLOT_F) begin
                    n_state = aifs_pkg::S_BOX;
                    n_slot  = aifs_pkg::SLOT_A;
                end else begin
                    n_state = aifs_pkg::S_READ;
                    n_slot  = aifs_pkg::SLOT_C;
                end
            end
            aifs_pkg::S_BOX: begin
                n_state = aifs_pkg::S_DONE;
            end
            aifs_pkg::S_DONE: begin
                if (i_out_free) begin
                    n_state = aifs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = aifs_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ctrl          = '0;
        o_ctrl.ram_re   = (r_state == aifs_pkg::S_READ);
        o_ctrl.mul      = (r_state == aifs_pkg::S_MUL);
        o_ctrl.acc      = (r_state == aifs_pkg::S_ACC);
        o_ctrl.term     = (r_state == aifs_pkg::S_TERM);
        o_ctrl.coef_add = (r_state == aifs_pkg::S_ADD);
        o_ctrl.sum_clr  = (r_state == aifs_pkg::S_IDLE && i_start) ||
                          (r_state == aifs_pkg::S_ADD && r_slot == aifs_pkg::SLOT_E);
        o_ctrl.store_x  = (r_state == aifs_pkg::S_ADD && r_slot == aifs_pkg::SLOT_E);
        o_ctrl.store_y  = (r_state == aifs_pkg::S_ADD && r_slot == aifs_pkg::SLOT_F);
        o_ctrl.box      = (r_state == aifs_pkg::S_BOX);
        o_ctrl.done     = (r_state == aifs_pkg::S_DONE && i_out_free);
    end

    assign o_state = r_state;
    assign o_slot  = r_slot;
    assign o_pass  = r_pass;

endmodule

// ----- rtl/affine_ifs_point_generator.sv -----
`timescale 1ns / 1ps
// Top level of the chaos-game point generator for an affine iterated function system.
//
// Input channel (i_in_valid / o_in_stall / i_in_data) carries one command per
// transaction: load a coefficient, load a cumulative threshold, step, or restart.
// Loads and restart take effect at the accepting edge and produce no result.
// A step picks a map from its random percent, then runs the six coefficients of
// that map through one shared multiplier and adder; o_in_stall is high until the
// step result has been handed to the output register.
// Each of the four products takes a coefficient read, NPASS multiply/accumulate
// pairs and one term add, NPASS being the number of multiplier passes per product
// (POINT_WIDTH/32 rounded up); each offset takes a read and an add. No new step is
// accepted until the result of the last one has reached the output register.
// Non-step commands are accepted one per cycle while no step is in progress.
// Output channel (o_out_valid / i_out_stall / o_out_data) holds one registered
// result; while the receiver stalls, the result holds and the block may still
// accept loads, but a finished step waits in its last state.
// Reset clears the point to the origin, the step count and the bounding box,
// sets all thresholds to 100, marks all coefficients as zero and restores the
// configuration registers (maps_in_use at 0x0, warmup_steps at 0x4).
module affine_ifs_point_generator #(
    parameter int MAX_MAPS    = aifs_pkg::MAX_MAPS_DEF,
    parameter int POINT_WIDTH = aifs_pkg::POINT_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // command channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  aifs_pkg::t_in_item  i_in_data,
    // result channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output aifs_pkg::t_out_item o_out_data,
    // register port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int NPASS   = (POINT_WIDTH + 31) / 32;
    localparam int PASS_W  = (NPASS > 1) ? $clog2(NPASS) : 1;
    localparam int NCOEF   = MAX_MAPS * aifs_pkg::COEFS_PER_MAP;
    localparam int CADDR_W = $clog2(NCOEF);
    localparam int MAP_W   = (MAX_MAPS > 1) ? $clog2(MAX_MAPS) : 1;

    localparam logic signed [POINT_WIDTH-1:0] PT_MAX = {1'b0, {(POINT_WIDTH - 1){1'b1}}};
    localparam logic signed [POINT_WIDTH-1:0] PT_MIN = {1'b1, {(POINT_WIDTH - 1){1'b0}}};

    // configuration and tables
    logic [3:0]  r_maps;
    logic [15:0] r_warmup;
    logic [6:0]  r_thr [MAX_MAPS];
    logic [NCOEF-1:0] r_cvalid;

    // architectural point state
    logic signed [POINT_WIDTH-1:0] r_x, r_y, r_nx, r_ny;
    logic signed [POINT_WIDTH-1:0] r_bxl, r_bxh, r_byl, r_byh;
    logic [15:0] r_step;

    // step working registers
    logic [MAP_W-1:0] r_map;
    logic             r_cv;
    logic             r_counted;

    logic                r_out_valid;
    aifs_pkg::t_out_item r_out;

    // control from the sequencer
    aifs_pkg::t_state  w_state;
    aifs_pkg::t_ctrl   w_ctrl;
    aifs_pkg::t_slot   w_slot;
    logic [PASS_W-1:0] w_pass;

    logic                          w_accept, w_start, w_out_free, w_coef_ok, w_counted;
    logic                          w_cfg_wr;
    aifs_pkg::t_reg_idx            w_reg;
    logic [4:0]                    w_mu;
    logic [MAP_W-1:0]              w_sel_map;
    logic [CADDR_W-1:0]            w_waddr, w_raddr;
    logic [POINT_WIDTH-1:0]        w_wdata, w_rdata;
    logic signed [POINT_WIDTH-1:0] w_coef, w_point, w_sat;

    // ---------------------------------------------------------------- handshakes
    assign o_in_stall = (w_state != aifs_pkg::S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_start    = w_accept && (i_in_data.cmd == aifs_pkg::CMD_STEP);
    assign w_out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ---------------------------------------------------------------- register port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign w_reg    = aifs_pkg::t_reg_idx'(paddr[2]);
    assign prdata   = (w_reg == aifs_pkg::REG_WARMUP_STEPS) ? {16'd0, r_warmup}
                                                            : {28'd0, r_maps};

    // ---------------------------------------------------------------- map selection
    // First map in use whose threshold exceeds the draw; else the last map in use.
    always_comb begin
        if (r_maps == 4'd0) begin
            w_mu = 5'd1;
        end else if (5'(r_maps) > 5'(MAX_MAPS)) begin
            w_mu = 5'(MAX_MAPS);
        end else begin
            w_mu = 5'(r_maps);
        end
        w_sel_map = MAP_W'(w_mu - 5'd1);
        for (int i = MAX_MAPS - 1; i >= 0; i--) begin
            if (5'(i) < w_mu && i_in_data.random_percent < r_thr[i]) begin
                w_sel_map = MAP_W'(i);
            end
        end
    end

    // ---------------------------------------------------------------- coefficient store
    // Drop loads to a slot above f or a map beyond the table.
    assign w_coef_ok = (int'(i_in_data.map_index) < MAX_MAPS) &&
                       (int'(i_in_data.coef_index) < aifs_pkg::COEFS_PER_MAP);
    assign w_waddr   = CADDR_W'(int'(i_in_data.map_index) * aifs_pkg::COEFS_PER_MAP +
                                int'(i_in_data.coef_index));
    assign w_wdata   = POINT_WIDTH'(i_in_data.load_value);
    assign w_raddr   = CADDR_W'(int'(r_map) * aifs_pkg::COEFS_PER_MAP + int'(w_slot));

    aifs_ram #(
        .WIDTH (POINT_WIDTH),
        .DEPTH (NCOEF)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (w_accept && i_in_data.cmd == aifs_pkg::CMD_LOAD_COEF && w_coef_ok),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_ctrl.ram_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Never-written entries read as zero.
    assign w_coef  = r_cv ? signed'(w_rdata) : '0;
    assign w_point = (w_slot == aifs_pkg::SLOT_A || w_slot == aifs_pkg::SLOT_C) ? r_x : r_y;

    // ---------------------------------------------------------------- sequencer and unit
    aifs_seq #(
        .POINT_WIDTH (POINT_WIDTH)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_out_free (w_out_free),
        .o_state    (w_state),
        .o_ctrl     (w_ctrl),
        .o_slot     (w_slot),
        .o_pass     (w_pass)
    );

    aifs_mac #(
        .POINT_WIDTH (POINT_WIDTH)
    ) u_mac (
        .i_clk   (i_clk),
        .i_ctrl  (w_ctrl),
        .i_pass  (w_pass),
        .i_coef  (w_coef),
        .i_point (w_point),
        .o_sat   (w_sat)
    );

    // Counts toward the box once the step number reaches the warm-up value.
    assign w_counted = (17'(r_step) + 17'd1) >= 17'(r_warmup);

    // ---------------------------------------------------------------- state with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_maps      <= aifs_pkg::MAPS_IN_USE_RESET;
            r_warmup    <= aifs_pkg::WARMUP_RESET;
            for (int i = 0; i < MAX_MAPS; i++) begin
                r_thr[i] <= aifs_pkg::THRESH_RESET;
            end
            r_cvalid    <= '0;
            r_x         <= '0;
            r_y         <= '0;
            r_step      <= '0;
            r_bxl       <= PT_MAX;
            r_bxh       <= PT_MIN;
            r_byl       <= PT_MAX;
            r_byh       <= PT_MIN;
            r_out_valid <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                case (w_reg)
                    aifs_pkg::REG_MAPS_IN_USE:  r_maps   <= pwdata[3:0];
                    aifs_pkg::REG_WARMUP_STEPS: r_warmup <= pwdata[15:0];
                    default: ;
                endcase
            end

            if (w_accept) begin
                case (i_in_data.cmd)
                    aifs_pkg::CMD_LOAD_COEF: begin
                        if (w_coef_ok) begin
                            r_cvalid[w_waddr] <= 1'b1;
                        end
                    end
                    aifs_pkg::CMD_LOAD_THRESH: begin
                        for (int i = 0; i < MAX_MAPS; i++) begin
                            if (int'(i_in_data.map_index) == i) begin
                                r_thr[i] <= i_in_data.load_value[6:0];
                            end
                        end
                    end
                    aifs_pkg::CMD_RESTART: begin
                        // back to the origin; tables and registers stay
                        r_x    <= '0;
                        r_y    <= '0;
                        r_step <= '0;
                        r_bxl  <= PT_MAX;
                        r_bxh  <= PT_MIN;
                        r_byl  <= PT_MAX;
                        r_byh  <= PT_MIN;
                    end
                    default: ;
                endcase
            end

            // commit the new point, widen the box, advance the saturating count
            if (w_ctrl.box) begin
                r_x <= r_nx;
                r_y <= r_ny;
                if (w_counted) begin
                    if (r_nx < r_bxl) r_bxl <= r_nx;
                    if (r_nx > r_bxh) r_bxh <= r_nx;
                    if (r_ny < r_byl) r_byl <= r_ny;
                    if (r_ny > r_byh) r_byh <= r_ny;
                end
                if (r_step != aifs_pkg::STEP_COUNT_MAX) begin
                    r_step <= r_step + 16'd1;
                end
            end

            if (w_ctrl.done) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- payload registers
    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_map <= w_sel_map;
        end
        if (w_ctrl.ram_re) begin
            r_cv <= r_cvalid[w_raddr];
        end
        if (w_ctrl.store_x) begin
            r_nx <= w_sat;
        end
        if (w_ctrl.store_y) begin
            r_ny <= w_sat;
        end
        if (w_ctrl.box) begin
            r_counted <= w_counted;
        end
        if (w_ctrl.done) begin
            r_out.point_x     <= 32'(r_x);
            r_out.point_y     <= 32'(r_y);
            r_out.map_chosen  <= 3'(r_map);
            r_out.past_warmup <= r_counted;
            r_out.box_x_min   <= 32'(r_bxl);
            r_out.box_x_max   <= 32'(r_bxh);
            r_out.box_y_min   <= 32'(r_byl);
            r_out.box_y_max   <= 32'(r_byh);
        end
    end

    // ---------------------------------------------------------------- assertions
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_slot <= aifs_pkg::SLOT_F)
        else $error("coefficient slot beyond f");

    a_box_holds_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_state == aifs_pkg::S_DONE && r_counted) |->
            (r_bxl <= r_x && r_x <= r_bxh && r_byl <= r_y && r_y <= r_byh))
        else $error("counted point lies outside the bounding box");

    a_result_from_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_state == aifs_pkg::S_DONE))
        else $error("result raised outside the end of a step");

    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_data.cmd == aifs_pkg::CMD_RESTART) |=>
            (r_step == 16'd0 && r_x == '0 && r_y == '0))
        else $error("restart did not return to the origin");

endmodule
